>>> rtl/core/mtm_pkg.sv
// ============================================================================
// mtm_pkg
// Shared types, opcodes and datapath command encodings for the
// memory-to-memory processor core.
// ============================================================================
`default_nettype none

package mtm_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] value;
    logic [15:0] port_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_pc;
    logic [1:0]  event_res;
    logic [15:0] event_port;
    logic [15:0] event_value;
    logic [15:0] read_data;
  } out_item_t;

  // item kinds
  localparam logic [1:0] KIND_LDC = 2'd0;
  localparam logic [1:0] KIND_LDD = 2'd1;
  localparam logic [1:0] KIND_EXE = 2'd2;
  localparam logic [1:0] KIND_RDD = 2'd3;

  // stop codes
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_UNK   = 3'd2;
  localparam logic [2:0] ST_MODE  = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;
  localparam logic [2:0] ST_PCLIM = 3'd5;

  // port events
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_WRITE = 2'd1;
  localparam logic [1:0] EV_READ  = 2'd2;
  localparam logic [1:0] EV_SLEEP = 2'd3;

  // operand modes
  localparam logic [1:0] MODE_DIR = 2'd0;
  localparam logic [1:0] MODE_IMM = 2'd1;
  localparam logic [1:0] MODE_STK = 2'd2;
  localparam logic [1:0] MODE_BAD = 2'd3;

  // opcodes
  localparam logic [7:0] OP_NOP   = 8'h00;
  localparam logic [7:0] OP_MOV   = 8'h01;
  localparam logic [7:0] OP_PUSH  = 8'h02;
  localparam logic [7:0] OP_POP   = 8'h03;
  localparam logic [7:0] OP_SUB   = 8'h04;
  localparam logic [7:0] OP_ADD   = 8'h05;
  localparam logic [7:0] OP_MUL   = 8'h06;
  localparam logic [7:0] OP_DIV   = 8'h07;
  localparam logic [7:0] OP_MOD   = 8'h08;
  localparam logic [7:0] OP_EQ    = 8'h09;
  localparam logic [7:0] OP_NEQ   = 8'h0A;
  localparam logic [7:0] OP_LT    = 8'h0B;
  localparam logic [7:0] OP_GT    = 8'h0C;
  localparam logic [7:0] OP_LAND  = 8'h0D;
  localparam logic [7:0] OP_AND   = 8'h0E;
  localparam logic [7:0] OP_OR    = 8'h0F;
  localparam logic [7:0] OP_JMP   = 8'h10;
  localparam logic [7:0] OP_JMPR  = 8'h11;
  localparam logic [7:0] OP_OUT   = 8'h12;
  localparam logic [7:0] OP_IN    = 8'h13;
  localparam logic [7:0] OP_SLEEP = 8'h14;
  localparam logic [7:0] OP_SSP   = 8'h15;
  localparam logic [7:0] OP_MSS   = 8'h16;
  localparam logic [7:0] OP_PUSHS = 8'h17;
  localparam logic [7:0] OP_POPS  = 8'h18;
  localparam logic [7:0] OP_MSET  = 8'h19;
  localparam logic [7:0] OP_MMOV  = 8'h1A;
  localparam logic [7:0] OP_HALT  = 8'hFF;
  localparam logic [7:0] OP_LAST  = OP_MMOV;

  // words kept clear of the top of the code store
  localparam int PC_GUARD = 10;

  typedef enum logic [1:0] {DOP_NONE, DOP_RD, DOP_WR, DOP_PUT} dop_t;

  typedef enum logic [3:0] {
    DA_CLR, DA_ITEM, DA_SP, DA_OPND, DA_TOP, DA_A, DA_B, DA_BDST, DA_BSRC
  } dsel_t;

  typedef enum logic [3:0] {
    WD_ZERO, WD_ITEM, WD_TOPDEC, WD_TOPINC, WD_V0, WD_V1, WD_ALU, WD_PDATA, WD_RDATA
  } wsel_t;

  typedef enum logic [1:0] {DD_NONE, DD_TOP, DD_V} ddst_t;

  typedef enum logic [1:0] {RES_PLAIN, RES_READ, RES_EXEC} res_t;

  typedef struct packed {
    logic       clr;
    logic       accept;
    logic       item_cwr;
    logic       crd;
    logic [2:0] cidx;
    dop_t       dop;
    dsel_t      dsel;
    wsel_t      wsel;
    ddst_t      ddst;
    logic [1:0] opk;
    logic       blk_init;
    logic       blk_step;
    logic       div_start;
    logic       out_ld;
    res_t       res;
    logic [2:0] fault;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       out_free;
    logic       stopped;
    logic [7:0] op;
    logic [7:0] modes;
    logic       v1_zero;
    logic       blk_end;
    logic       blk_ok;
    logic       div_busy;
  } sts_t;

  function automatic logic [1:0] mode_of(input logic [7:0] modes, input logic [1:0] k);
    logic [1:0] m;
    case (k)
      2'd0:    m = modes[7:6];
      2'd1:    m = modes[5:4];
      2'd2:    m = modes[3:2];
      default: m = modes[1:0];
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mtm_ram.sv
// ============================================================================
// mtm_ram
// Single-port RAM, one access per cycle, registered read data.
// ============================================================================
`default_nettype none

module mtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/mtm_div.sv
// ============================================================================
// mtm_div
// 16-bit unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module mtm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [15:0]      quo,
  output logic [15:0]      rem
);

  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [15:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] d_r;
  logic [16:0] shifted;
  logic [17:0] diff;
  logic        ge;

  assign shifted = {rem_r, quo_r[15]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign ge      = ~diff[17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd16;
      quo_r  <= dividend;
      rem_r  <= '0;
      d_r    <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[15:0] : shifted[15:0];
      quo_r <= {quo_r[14:0], ge};
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> rtl/core/mtm_dp.sv
// ============================================================================
// mtm_dp
// Datapath: code and data stores, machine registers, operand and block
// address generation, ALU, divider and the result register.
// ============================================================================
`default_nettype none

module mtm_dp #(
  parameter int MEMORY_WORDS = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtm_pkg::in_item_t in_data,
  input  wire mtm_pkg::cmd_t     cmd,
  output mtm_pkg::sts_t          sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mtm_pkg::out_item_t     out_data
);

  import mtm_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam logic [16:0] MW17  = 17'(MEMORY_WORDS);
  localparam logic [16:0] LIMIT = 17'(MEMORY_WORDS - PC_GUARD);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEMORY_WORDS - 1);

  logic [15:0]       pc_r, sp_r, top_r, ins_r, pdata_r, i_r;
  logic [2:0]        stop_r;
  logic [3:0][15:0]  w_r;
  logic [3:0][15:0]  v_r;
  logic [AW-1:0]     clr_r;
  logic              crd_d_r;
  logic [2:0]        cidx_d_r;
  ddst_t             ddst_d_r;
  logic [1:0]        opk_d_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [7:0]  op;
  logic [1:0]  opk_mode, opk_d_mode;
  logic [15:0] opnd_addr;
  logic [15:0] daddr;
  logic [15:0] dwdata;
  logic        dwe;
  logic [15:0] drdata;
  logic [AW-1:0] caddr;
  logic [15:0] cwdata;
  logic        cwe;
  logic [15:0] crdata;
  logic [15:0] alu;
  logic [31:0] prod;
  logic [15:0] quo, rem;
  logic        div_busy;
  logic        rev;
  logic [15:0] j;
  logic [16:0] dst_j, src_j;
  logic        blk_ok;
  logic        fin;
  logic [15:0] p, pc_n, sp_n, evp_n, evv_n;
  logic [1:0]  ev_n;
  logic [2:0]  stop_n;

  assign op         = ins_r[7:0];
  assign opk_mode   = mode_of(ins_r[15:8], cmd.opk);
  assign opk_d_mode = mode_of(ins_r[15:8], opk_d_r);
  assign opnd_addr  = (opk_mode == MODE_STK) ? top_r + w_r[cmd.opk] : w_r[cmd.opk];

  // block transfer addressing; a move runs backward when the source lies below
  assign rev   = (op == OP_MMOV) && (v_r[1] < v_r[0]);
  assign j     = rev ? v_r[2] - 16'd1 - i_r : i_r;
  assign dst_j = {1'b0, v_r[0]} + {1'b0, j};
  assign src_j = {1'b0, v_r[1]} + {1'b0, j};
  assign blk_ok = (op == OP_MMOV) ? (dst_j < MW17) && (src_j < MW17) : (dst_j < MW17);

  always_comb begin
    case (cmd.dsel)
      DA_CLR:  daddr = 16'(clr_r);
      DA_ITEM: daddr = in_data.address;
      DA_SP:   daddr = sp_r;
      DA_OPND: daddr = opnd_addr;
      DA_TOP:  daddr = top_r;
      DA_A:    daddr = v_r[0] + v_r[1];
      DA_B:    daddr = v_r[2] + v_r[3];
      DA_BDST: daddr = dst_j[15:0];
      DA_BSRC: daddr = src_j[15:0];
      default: daddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wsel)
      WD_ITEM:   dwdata = in_data.value;
      WD_TOPDEC: dwdata = top_r - 16'd1;
      WD_TOPINC: dwdata = top_r + 16'd1;
      WD_V0:     dwdata = v_r[0];
      WD_V1:     dwdata = v_r[1];
      WD_ALU:    dwdata = alu;
      WD_PDATA:  dwdata = pdata_r;
      WD_RDATA:  dwdata = drdata;
      default:   dwdata = '0;
    endcase
  end

  assign dwe = cmd.clr || (cmd.dop == DOP_WR) ||
               ((cmd.dop == DOP_PUT) && (opk_mode != MODE_IMM));

  mtm_ram #(.WIDTH(16), .DEPTH(MEMORY_WORDS)) u_data (
    .clk   (clk),
    .we    (dwe),
    .addr  (daddr[AW-1:0]),
    .wdata (dwdata),
    .rdata (drdata)
  );

  always_comb begin
    if (cmd.clr) begin
      caddr = clr_r;
    end else if (cmd.item_cwr) begin
      caddr = in_data.address[AW-1:0];
    end else begin
      caddr = AW'(pc_r + {13'd0, cmd.cidx});
    end
  end

  assign cwe    = cmd.clr || cmd.item_cwr;
  assign cwdata = cmd.clr ? 16'd0 : in_data.value;

  mtm_ram #(.WIDTH(16), .DEPTH(MEMORY_WORDS)) u_code (
    .clk   (clk),
    .we    (cwe),
    .addr  (caddr),
    .wdata (cwdata),
    .rdata (crdata)
  );

  mtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (v_r[0]),
    .divisor  (v_r[1]),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  assign prod = v_r[0] * v_r[1];

  always_comb begin
    case (op)
      OP_SUB:  alu = v_r[0] - v_r[1];
      OP_ADD:  alu = v_r[0] + v_r[1];
      OP_MUL:  alu = prod[15:0];
      OP_DIV:  alu = quo;
      OP_MOD:  alu = rem;
      OP_EQ:   alu = {15'd0, v_r[0] == v_r[1]};
      OP_NEQ:  alu = {15'd0, v_r[0] != v_r[1]};
      OP_LT:   alu = {15'd0, v_r[0] < v_r[1]};
      OP_GT:   alu = {15'd0, v_r[0] > v_r[1]};
      OP_LAND: alu = {15'd0, (v_r[0] != 16'd0) && (v_r[1] != 16'd0)};
      OP_AND:  alu = v_r[0] & v_r[1];
      OP_OR:   alu = v_r[0] | v_r[1];
      default: alu = '0;
    endcase
  end

  // end-of-instruction state update
  assign p   = pc_r + 16'd1;
  assign fin = cmd.out_ld && (cmd.res == RES_EXEC);

  always_comb begin
    pc_n   = p;
    sp_n   = sp_r;
    ev_n   = EV_NONE;
    evp_n  = '0;
    evv_n  = '0;
    stop_n = cmd.fault;
    if (cmd.fault == ST_RUN) begin
      case (op) inside
        OP_MOV, [OP_SUB:OP_OR], OP_PUSHS, OP_POPS: pc_n = p + 16'd2;
        OP_PUSH, OP_POP:  pc_n = p + 16'd1;
        OP_MSS:           pc_n = p + 16'd4;
        OP_MSET, OP_MMOV: pc_n = p + 16'd3;
        OP_JMP:  pc_n = (v_r[1] == 16'd0) ? v_r[0] : p + 16'd2;
        OP_JMPR: pc_n = (v_r[1] == 16'd0) ? p + v_r[0] : p + 16'd2;
        OP_OUT: begin
          pc_n  = p + 16'd2;
          ev_n  = EV_WRITE;
          evp_n = v_r[0];
          evv_n = v_r[1];
        end
        OP_IN: begin
          pc_n  = p + 16'd2;
          ev_n  = EV_READ;
          evp_n = v_r[1];
          evv_n = pdata_r;
        end
        OP_SLEEP: begin
          pc_n  = p + 16'd1;
          ev_n  = EV_SLEEP;
          evv_n = v_r[0];
        end
        OP_SSP: begin
          pc_n = p + 16'd1;
          sp_n = v_r[0];
        end
        default: pc_n = p;
      endcase
      stop_n = ({1'b0, pc_n} >= LIMIT) ? ST_PCLIM : ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      sp_r        <= '0;
      stop_r      <= ST_RUN;
      clr_r       <= '0;
      crd_d_r     <= 1'b0;
      ddst_d_r    <= DD_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + 1'b1;
      end
      crd_d_r  <= cmd.crd;
      ddst_d_r <= (cmd.dop == DOP_RD) ? cmd.ddst : DD_NONE;
      if (fin) begin
        pc_r   <= pc_n;
        sp_r   <= sp_n;
        stop_r <= stop_n;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cidx_d_r <= cmd.cidx;
    opk_d_r  <= cmd.opk;
    if (cmd.accept) begin
      pdata_r <= in_data.port_data;
    end
    if (crd_d_r) begin
      case (cidx_d_r)
        3'd0:    ins_r  <= crdata;
        3'd1:    w_r[0] <= crdata;
        3'd2:    w_r[1] <= crdata;
        3'd3:    w_r[2] <= crdata;
        default: w_r[3] <= crdata;
      endcase
    end
    // top_r mirrors data[sp]: follow any write that lands on the stack cell
    if (dwe && (daddr[AW-1:0] == sp_r[AW-1:0])) begin
      top_r <= dwdata;
    end else if (ddst_d_r == DD_TOP) begin
      top_r <= drdata;
    end
    if (ddst_d_r == DD_V) begin
      v_r[opk_d_r] <= (opk_d_mode == MODE_IMM) ? w_r[opk_d_r] : drdata;
    end
    if (cmd.blk_init) begin
      i_r <= '0;
    end else if (cmd.blk_step) begin
      i_r <= i_r + 16'd1;
    end
    if (cmd.out_ld) begin
      out_r.event_res   <= EV_NONE;
      out_r.event_port  <= '0;
      out_r.event_value <= '0;
      out_r.read_data   <= '0;
      out_r.status      <= stop_r;
      out_r.next_pc     <= pc_r;
      case (cmd.res)
        RES_READ: out_r.read_data <= drdata;
        RES_EXEC: begin
          out_r.status      <= stop_n;
          out_r.next_pc     <= pc_n;
          out_r.event_res   <= ev_n;
          out_r.event_port  <= evp_n;
          out_r.event_value <= evv_n;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts          = '0;
    sts.clr_last = (clr_r == CLR_LAST);
    sts.out_free = !out_valid_r || out_ready;
    sts.stopped  = (stop_r != ST_RUN);
    sts.op       = op;
    sts.modes    = ins_r[15:8];
    sts.v1_zero  = (v_r[1] == 16'd0);
    sts.blk_end  = (i_r == v_r[2]);
    sts.blk_ok   = blk_ok;
    sts.div_busy = div_busy;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> rtl/core/mtm_ctrl.sv
// ============================================================================
// mtm_ctrl
// Sequencer: store clearing, item handling and per-opcode micro-steps.
// ============================================================================
`default_nettype none

module mtm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_kind,
  output logic               in_ready,
  input  wire mtm_pkg::sts_t sts,
  output mtm_pkg::cmd_t      cmd
);

  import mtm_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDW, S_FETCH, S_FLAST, S_DEC, S_SPDEC, S_GETV, S_GLAST,
    S_EX1, S_EX2, S_EX3, S_DIV, S_BLK, S_MOVW, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] fault_r, fault_nxt;
  logic [1:0] m0, m1, m2, m3;
  logic       bad;

  assign m0 = sts.modes[7:6];
  assign m1 = sts.modes[5:4];
  assign m2 = sts.modes[3:2];
  assign m3 = sts.modes[1:0];

  // mode fault on operands the opcode uses; jumps check later
  always_comb begin
    unique case (sts.op) inside
      OP_PUSH, OP_POP, OP_SLEEP, OP_SSP: bad = (m0 == MODE_BAD);
      OP_MSS: bad = (m0 == MODE_BAD) || (m1 == MODE_BAD) ||
                    (m2 == MODE_BAD) || (m3 == MODE_BAD);
      OP_MSET, OP_MMOV: bad = (m0 == MODE_BAD) || (m1 == MODE_BAD) || (m2 == MODE_BAD);
      OP_NOP, OP_JMP, OP_JMPR: bad = 1'b0;
      default: bad = (m0 == MODE_BAD) || (m1 == MODE_BAD);
    endcase
  end

  assign in_ready = (state_r == S_IDLE) &&
                    (sts.out_free || ((in_kind == KIND_EXE) && !sts.stopped));

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fault_nxt = fault_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          unique case (in_kind)
            KIND_LDC: begin
              cmd.item_cwr = 1'b1;
              cmd.out_ld   = 1'b1;
            end
            KIND_LDD: begin
              cmd.dop    = DOP_WR;
              cmd.dsel   = DA_ITEM;
              cmd.wsel   = WD_ITEM;
              cmd.out_ld = 1'b1;
            end
            KIND_RDD: begin
              cmd.dop   = DOP_RD;
              cmd.dsel  = DA_ITEM;
              state_nxt = S_RDW;
            end
            default: begin
              if (sts.stopped) begin
                cmd.out_ld = 1'b1;
              end else begin
                cnt_nxt   = '0;
                state_nxt = S_FETCH;
              end
            end
          endcase
        end
      end
      S_RDW: begin
        cmd.out_ld = 1'b1;
        cmd.res    = RES_READ;
        state_nxt  = S_IDLE;
      end
      S_FETCH: begin
        cmd.crd  = 1'b1;
        cmd.cidx = cnt_r;
        if (cnt_r == 3'd0) begin
          cmd.dop  = DOP_RD;
          cmd.dsel = DA_SP;
          cmd.ddst = DD_TOP;
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) state_nxt = S_FLAST;
      end
      S_FLAST: state_nxt = S_DEC;
      S_DEC: begin
        fault_nxt = ST_RUN;
        cnt_nxt   = '0;
        if (sts.op == OP_HALT) begin
          fault_nxt = ST_HALT;
          state_nxt = S_FIN;
        end else if (sts.op > OP_LAST) begin
          fault_nxt = ST_UNK;
          state_nxt = S_FIN;
        end else if (bad) begin
          fault_nxt = ST_MODE;
          state_nxt = S_FIN;
        end else if (sts.op == OP_PUSHS) begin
          state_nxt = S_SPDEC;
        end else begin
          state_nxt = S_GETV;
        end
      end
      S_SPDEC: begin
        cmd.dop   = DOP_WR;
        cmd.dsel  = DA_SP;
        cmd.wsel  = WD_TOPDEC;
        state_nxt = S_GETV;
      end
      S_GETV: begin
        cmd.dop  = DOP_RD;
        cmd.dsel = DA_OPND;
        cmd.ddst = DD_V;
        cmd.opk  = cnt_r[1:0];
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'd3) state_nxt = S_GLAST;
      end
      S_GLAST: state_nxt = S_EX1;
      S_EX1: begin
        state_nxt = S_FIN;
        case (sts.op) inside
          OP_MOV: begin
            cmd.dop  = DOP_PUT;
            cmd.dsel = DA_OPND;
            cmd.wsel = WD_V1;
          end
          OP_PUSH: begin
            cmd.dop   = DOP_WR;
            cmd.dsel  = DA_SP;
            cmd.wsel  = WD_TOPDEC;
            state_nxt = S_EX2;
          end
          OP_POP, OP_POPS: begin
            cmd.dop   = DOP_RD;
            cmd.dsel  = DA_TOP;
            state_nxt = S_EX2;
          end
          OP_DIV, OP_MOD: begin
            if (sts.v1_zero) begin
              fault_nxt = ST_DIV0;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          [OP_SUB:OP_OR]: begin
            cmd.dop  = DOP_PUT;
            cmd.dsel = DA_OPND;
            cmd.wsel = WD_ALU;
          end
          OP_JMP, OP_JMPR: begin
            if ((m1 == MODE_BAD) || (sts.v1_zero && (m0 == MODE_BAD))) begin
              fault_nxt = ST_MODE;
            end
          end
          OP_IN: begin
            cmd.dop  = DOP_PUT;
            cmd.dsel = DA_OPND;
            cmd.wsel = WD_PDATA;
          end
          OP_MSS: begin
            cmd.dop   = DOP_RD;
            cmd.dsel  = DA_B;
            state_nxt = S_EX2;
          end
          OP_PUSHS: begin
            cmd.dop   = DOP_RD;
            cmd.dsel  = DA_A;
            state_nxt = S_EX2;
          end
          OP_MSET, OP_MMOV: begin
            cmd.blk_init = 1'b1;
            state_nxt    = S_BLK;
          end
          default: ;
        endcase
      end
      S_EX2: begin
        state_nxt = S_FIN;
        case (sts.op) inside
          OP_PUSH: begin
            cmd.dop  = DOP_WR;
            cmd.dsel = DA_TOP;
            cmd.wsel = WD_V0;
          end
          OP_POP: begin
            cmd.dop   = DOP_PUT;
            cmd.dsel  = DA_OPND;
            cmd.wsel  = WD_RDATA;
            state_nxt = S_EX3;
          end
          OP_MSS: begin
            cmd.dop  = DOP_WR;
            cmd.dsel = DA_A;
            cmd.wsel = WD_RDATA;
          end
          OP_PUSHS: begin
            cmd.dop  = DOP_WR;
            cmd.dsel = DA_TOP;
            cmd.wsel = WD_RDATA;
          end
          OP_POPS: begin
            cmd.dop   = DOP_WR;
            cmd.dsel  = DA_A;
            cmd.wsel  = WD_RDATA;
            state_nxt = S_EX3;
          end
          OP_DIV, OP_MOD: begin
            cmd.dop  = DOP_PUT;
            cmd.dsel = DA_OPND;
            cmd.wsel = WD_ALU;
          end
          default: ;
        endcase
      end
      S_EX3: begin
        cmd.dop   = DOP_WR;
        cmd.dsel  = DA_SP;
        cmd.wsel  = WD_TOPINC;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        if (!sts.div_busy) state_nxt = S_EX2;
      end
      S_BLK: begin
        if (sts.blk_end) begin
          state_nxt = S_FIN;
        end else if (sts.op == OP_MSET) begin
          if (sts.blk_ok) begin
            cmd.dop  = DOP_WR;
            cmd.dsel = DA_BDST;
            cmd.wsel = WD_V1;
          end
          cmd.blk_step = 1'b1;
        end else if (sts.blk_ok) begin
          cmd.dop   = DOP_RD;
          cmd.dsel  = DA_BSRC;
          state_nxt = S_MOVW;
        end else begin
          cmd.blk_step = 1'b1;
        end
      end
      S_MOVW: begin
        cmd.dop      = DOP_WR;
        cmd.dsel     = DA_BDST;
        cmd.wsel     = WD_RDATA;
        cmd.blk_step = 1'b1;
        state_nxt    = S_BLK;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.res    = RES_EXEC;
          cmd.fault  = fault_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      fault_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/memory_to_memory_cpu_core.sv
// ============================================================================
// memory_to_memory_cpu_core
// 16-bit memory-to-memory processor with separate code and data stores.
// ============================================================================
// Input channel (in_valid/in_ready/in_data): each item loads a code word,
// loads a data word, reads a data word back, or executes one instruction.
// Result channel (out_valid/out_ready/out_data): exactly one result per item
// with stop status, program counter, port event and read data.
// Loads write the store as they are accepted; a read waits for the registered
// read data. An instruction makes five code-store reads for the instruction and
// operand words, four data-store reads for operand values, then up to three
// data-store accesses, all through the single port of each store. Halt and
// decode faults stop after decode. Divide and modulo wait on the bit-serial
// divider; block set writes each word, block move reads then writes each word
// on the data port.
// After reset both stores are swept to zero, one word per cycle, with in_ready
// low; pc, stack cell and status clear.
// MEMORY_WORDS must be a power of two. The result register lets an execute
// item be accepted while the previous result waits; if the receiver stalls,
// the next instruction holds its result until the register is free.
// ============================================================================
`default_nettype none

module memory_to_memory_cpu_core #(
  parameter int MEMORY_WORDS = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mtm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mtm_pkg::out_item_t      out_data
);

  import mtm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtm_dp #(.MEMORY_WORDS(MEMORY_WORDS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> dv/memory_to_memory_cpu_core_chk.sv
// ----------------------------------------------------------------------------
// memory_to_memory_cpu_core_chk
// Watches both channels of the core, keeps a shadow machine that works out
// the result of every accepted item, and compares each result field by field.
// ----------------------------------------------------------------------------
module memory_to_memory_cpu_core_chk #(
  parameter int MEMORY_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  mtm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  mtm_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mtm_pkg::*;

  localparam logic [31:0] AMASK = MEMORY_WORDS - 1;

  logic [15:0] code_mem [0:MEMORY_WORDS-1];
  logic [15:0] data_mem [0:MEMORY_WORDS-1];
  logic [15:0] pc_q;
  logic [15:0] sp_cell;
  logic [2:0]  stop_q;
  out_item_t   expected_results [$];

  function automatic logic [15:0] dread(logic [31:0] a);
    return data_mem[a & AMASK];
  endfunction

  function automatic void dwrite(logic [31:0] a, logic [15:0] v);
    data_mem[a & AMASK] = v;
  endfunction

  function automatic logic [15:0] opnd_rd(logic [1:0] m, logic [15:0] w);
    if (m == MODE_DIR) return dread(w);
    if (m == MODE_IMM) return w;
    return dread(16'(dread(sp_cell) + w));
  endfunction

  function automatic void opnd_wr(logic [1:0] m, logic [15:0] w, logic [15:0] v);
    if (m == MODE_DIR) dwrite(w, v);
    else if (m == MODE_STK) dwrite(16'(dread(sp_cell) + w), v);
  endfunction

  function automatic int operand_count(logic [7:0] op);
    if (op == OP_NOP || op == OP_HALT || op > OP_LAST) return 0;
    if (op == OP_PUSH || op == OP_POP || op == OP_SLEEP || op == OP_SSP) return 1;
    if (op == OP_MSS) return 4;
    if (op == OP_MSET || op == OP_MMOV) return 3;
    if (op == OP_JMP || op == OP_JMPR) return 0;
    return 2;
  endfunction

  function automatic void run_instr(logic [15:0] pdata, inout out_item_t r);
    logic [15:0] ins, p, a, b, v;
    logic [7:0]  op;
    logic [1:0]  m [4];
    logic [15:0] w [4];
    logic [31:0] res, dst, src, n, j;
    ins = code_mem[pc_q & AMASK];
    op  = ins[7:0];
    p   = pc_q + 16'd1;
    for (int k = 0; k < 4; k++) begin
      m[k] = ins[15-2*k -: 2];
      w[k] = code_mem[16'(p + k) & AMASK];
    end
    pc_q = p;
    if (op == OP_HALT) begin
      stop_q = ST_HALT;
      return;
    end
    if (op > OP_LAST) begin
      stop_q = ST_UNK;
      return;
    end
    for (int k = 0; k < operand_count(op); k++)
      if (m[k] == MODE_BAD) begin
        stop_q = ST_MODE;
        return;
      end
    case (op)
      OP_NOP: ;
      OP_MOV: begin
        opnd_wr(m[0], w[0], opnd_rd(m[1], w[1]));
        pc_q = p + 16'd2;
      end
      OP_PUSH: begin
        v = opnd_rd(m[0], w[0]);
        dwrite(sp_cell, dread(sp_cell) - 16'd1);
        dwrite(dread(sp_cell), v);
        pc_q = p + 16'd1;
      end
      OP_POP: begin
        v = dread(dread(sp_cell));
        opnd_wr(m[0], w[0], v);
        dwrite(sp_cell, dread(sp_cell) + 16'd1);
        pc_q = p + 16'd1;
      end
      OP_JMP, OP_JMPR: begin
        if (m[1] == MODE_BAD) begin
          stop_q = ST_MODE;
          return;
        end
        if (opnd_rd(m[1], w[1]) == 16'd0) begin
          if (m[0] == MODE_BAD) begin
            stop_q = ST_MODE;
            return;
          end
          a = opnd_rd(m[0], w[0]);
          pc_q = (op == OP_JMP) ? a : 16'(p + a);
        end else begin
          pc_q = p + 16'd2;
        end
      end
      OP_OUT: begin
        r.event_res   = EV_WRITE;
        r.event_port  = opnd_rd(m[0], w[0]);
        r.event_value = opnd_rd(m[1], w[1]);
        pc_q = p + 16'd2;
      end
      OP_IN: begin
        r.event_res   = EV_READ;
        r.event_port  = opnd_rd(m[1], w[1]);
        r.event_value = pdata;
        opnd_wr(m[0], w[0], pdata);
        pc_q = p + 16'd2;
      end
      OP_SLEEP: begin
        r.event_res   = EV_SLEEP;
        r.event_value = opnd_rd(m[0], w[0]);
        pc_q = p + 16'd1;
      end
      OP_SSP: begin
        sp_cell = opnd_rd(m[0], w[0]);
        pc_q = p + 16'd1;
      end
      OP_MSS: begin
        a = opnd_rd(m[0], w[0]) + opnd_rd(m[1], w[1]);
        b = opnd_rd(m[2], w[2]) + opnd_rd(m[3], w[3]);
        dwrite(a, dread(b));
        pc_q = p + 16'd4;
      end
      OP_PUSHS: begin
        dwrite(sp_cell, dread(sp_cell) - 16'd1);
        a = opnd_rd(m[0], w[0]) + opnd_rd(m[1], w[1]);
        dwrite(dread(sp_cell), dread(a));
        pc_q = p + 16'd2;
      end
      OP_POPS: begin
        a = opnd_rd(m[0], w[0]) + opnd_rd(m[1], w[1]);
        dwrite(a, dread(dread(sp_cell)));
        dwrite(sp_cell, dread(sp_cell) + 16'd1);
        pc_q = p + 16'd2;
      end
      OP_MSET: begin
        dst = opnd_rd(m[0], w[0]);
        v   = opnd_rd(m[1], w[1]);
        n   = opnd_rd(m[2], w[2]);
        for (logic [31:0] i = 0; i < n && dst + i < MEMORY_WORDS; i++) dwrite(dst + i, v);
        pc_q = p + 16'd3;
      end
      OP_MMOV: begin
        dst = opnd_rd(m[0], w[0]);
        src = opnd_rd(m[1], w[1]);
        n   = opnd_rd(m[2], w[2]);
        for (logic [31:0] i = 0; i < n; i++) begin
          j = (src < dst) ? (n - 1 - i) : i;
          if (src + j < MEMORY_WORDS && dst + j < MEMORY_WORDS) dwrite(dst + j, dread(src + j));
        end
        pc_q = p + 16'd3;
      end
      default: begin
        a = opnd_rd(m[0], w[0]);
        b = opnd_rd(m[1], w[1]);
        case (op)
          OP_SUB:  res = a - b;
          OP_ADD:  res = a + b;
          OP_MUL:  res = a * b;
          OP_DIV, OP_MOD: begin
            if (b == 16'd0) begin
              stop_q = ST_DIV0;
              return;
            end
            res = (op == OP_DIV) ? a / b : a % b;
          end
          OP_EQ:   res = a == b;
          OP_NEQ:  res = a != b;
          OP_LT:   res = a < b;
          OP_GT:   res = a > b;
          OP_LAND: res = (a != 0) && (b != 0);
          OP_AND:  res = a & b;
          default: res = a | b;
        endcase
        opnd_wr(m[0], w[0], res[15:0]);
        pc_q = p + 16'd2;
      end
    endcase
    if ({16'd0, pc_q} >= MEMORY_WORDS - PC_GUARD) stop_q = ST_PCLIM;
  endfunction

  function automatic out_item_t predict_item(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.kind)
      KIND_LDC: code_mem[it.address & AMASK] = it.value;
      KIND_LDD: dwrite(it.address, it.value);
      KIND_RDD: r.read_data = dread(it.address);
      default:  if (stop_q == ST_RUN) run_instr(it.port_data, r);
    endcase
    r.status  = stop_q;
    r.next_pc = pc_q;
    return r;
  endfunction

  task automatic cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    foreach (code_mem[i]) code_mem[i] = '0;
    foreach (data_mem[i]) data_mem[i] = '0;
    pc_q = '0;
    sp_cell = '0;
    stop_q = ST_RUN;
  end

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      // results first: an item accepted on this edge cannot have produced one
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          cmp_field("status", 16'(e.status), 16'(out_data.status));
          cmp_field("next_pc", e.next_pc, out_data.next_pc);
          cmp_field("event_res", 16'(e.event_res), 16'(out_data.event_res));
          cmp_field("event_port", e.event_port, out_data.event_port);
          cmp_field("event_value", e.event_value, out_data.event_value);
          cmp_field("read_data", e.read_data, out_data.read_data);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_item(in_data));
    end
  end
endmodule

>>> dv/memory_to_memory_cpu_core_tb.sv
// ----------------------------------------------------------------------------
// memory_to_memory_cpu_core_tb
// Builds short programs in the code store one instruction at a time, runs
// them with random operand modes and data, and ends with one stop condition.
// ----------------------------------------------------------------------------
module memory_to_memory_cpu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        errors;
  int        pending;

  int          sent_n = 0;
  int          got_n = 0;
  logic [15:0] last_pc = '0;
  logic [15:0] cur_pc = '0;
  bit          calm = 1'b0;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;

  memory_to_memory_cpu_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  memory_to_memory_cpu_core_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) begin
      got_n   <= got_n + 1;
      last_pc <= out_data.next_pc;
    end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (stall_req && !stall_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        stall_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [15:0] addr, logic [15:0] val);
    in_item_t it;
    it.kind      = kind;
    it.address   = addr;
    it.value     = val;
    it.port_data = 16'($urandom());
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent_n++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (got_n != sent_n) @(posedge clk);
    cur_pc = last_pc;
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom_range(0, 63));
      2:       return 16'($urandom_range(16'hFFC0, 16'hFFFF));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int used_slots(logic [7:0] op);
    if (op == OP_NOP) return 0;
    if (op == OP_PUSH || op == OP_POP || op == OP_SLEEP || op == OP_SSP) return 1;
    if (op == OP_MSS) return 4;
    if (op == OP_MSET || op == OP_MMOV) return 3;
    return 2;
  endfunction

  // place one instruction at the current pc, then execute it
  task automatic run_op(logic [7:0] op);
    logic [1:0]  m [4];
    logic [15:0] w [4];
    logic [15:0] tgt;
    for (int k = 0; k < 4; k++) begin
      m[k] = (k < used_slots(op)) ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
      w[k] = pick_addr();
    end
    case (op)
      OP_DIV, OP_MOD: begin
        m[1] = MODE_IMM;
        w[1] = 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 1)) w[1] = 16'($urandom_range(1, 9));
      end
      OP_JMP, OP_JMPR: begin
        tgt = 16'($urandom_range(0, 16'hFF00));
        m[1] = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 2)) : MODE_IMM;
        if (m[1] == MODE_IMM && $urandom_range(0, 3) != 0) w[1] = '0;
        if (m[1] == MODE_IMM && w[1] != 0) begin
          m[0] = 2'($urandom_range(0, 3));  // not taken: target mode is free
        end else begin
          m[0] = MODE_IMM;
          w[0] = (op == OP_JMP) ? tgt : 16'(tgt - (cur_pc + 16'd1));
        end
      end
      OP_MSET, OP_MMOV: begin
        m[2] = MODE_IMM;
        w[2] = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(0, 400))
                                            : 16'($urandom_range(0, 8));
        if ($urandom_range(0, 5) == 0) begin
          m[0] = MODE_IMM;
          w[0] = 16'($urandom_range(16'hFFF8, 16'hFFFF));
        end
      end
      default: ;
    endcase
    send_item(KIND_LDC, cur_pc, {m[0], m[1], m[2], m[3], op});
    for (int k = 0; k < 4; k++) send_item(KIND_LDC, 16'(cur_pc + 1 + k), w[k]);
    repeat ($urandom_range(0, 2)) send_item(KIND_LDD, pick_addr(), 16'($urandom()));
    if ($urandom_range(0, 3) == 0) send_item(KIND_RDD, pick_addr(), 16'($urandom()));
    send_item(KIND_EXE, 16'($urandom()), 16'($urandom()));
    drain_results();
  endtask

  function automatic logic [7:0] pick_op();
    return 8'($urandom_range(OP_NOP, OP_LAST));
  endfunction

  // one terminal stop, chosen by the seed
  task automatic stop_machine();
    logic [7:0] op;
    logic [1:0] m0, m1;
    logic [15:0] w0, w1;
    m0 = MODE_IMM;
    m1 = MODE_IMM;
    w0 = 16'd7;
    w1 = 16'd0;
    case ($urandom_range(0, 4))
      0: op = OP_HALT;
      1: op = 8'($urandom_range(OP_LAST + 1, OP_HALT - 1));
      2: begin
        op = OP_ADD;
        m0 = MODE_BAD;
      end
      3: op = OP_DIV;
      default: begin
        op = OP_JMP;
        w0 = 16'($urandom_range(16'hFFF6, 16'hFFFF));
      end
    endcase
    send_item(KIND_LDC, cur_pc, {m0, m1, 4'd0, op});
    send_item(KIND_LDC, cur_pc + 16'd1, w0);
    send_item(KIND_LDC, cur_pc + 16'd2, w1);
    repeat (4) send_item(KIND_EXE, 16'($urandom()), 16'($urandom()));
    send_item(KIND_LDD, 16'h0005, 16'h5A5A);
    send_item(KIND_RDD, 16'h0005, '0);
  endtask

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed: store extremes, then every opcode except halt once
    send_item(KIND_RDD, 16'hFFFF, 16'hFFFF);
    send_item(KIND_LDD, 16'hFFFF, 16'hFFFF);
    send_item(KIND_RDD, 16'hFFFF, '0);
    send_item(KIND_LDD, 16'h0000, 16'h0000);
    send_item(KIND_RDD, 16'h8000, 16'h8000);
    send_item(KIND_EXE, '0, '0);  // zeroed code store runs as nop
    drain_results();
    for (int op = OP_NOP; op <= OP_LAST; op++) run_op(8'(op));

    while (sent_n < 1500) begin
      if (!stall_req && sent_n > 600) begin
        stall_req = 1'b1;
        repeat (50) begin
          send_item(KIND_LDD, pick_addr(), 16'($urandom()));
          send_item(KIND_RDD, pick_addr(), '0);
        end
        drain_results();
      end
      run_op(pick_op());
    end
    calm = 1'b1;
    while (sent_n < 1740) run_op(pick_op());
    stop_machine();

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
